// File: hw/rtl/clp_pkg.sv
package clp_pkg;

    localparam int COORD_W = 24;
    localparam int DOT_W   = 50;
    localparam int PROD_W  = 100;
    localparam int DEN_W   = 97;
    localparam int NUM_W   = 99;
    localparam int Q_W     = 41;
    localparam int T_W     = 40;
    localparam int LIM_W   = 48;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 48'd281474977;
    localparam logic signed [T_W-1:0] T_MAX = 40'sh7FFFFFFFFF;
    localparam logic signed [T_W-1:0] T_MIN = 40'sh8000000000;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t [2:0] p1;
        coord_t [2:0] d1;
        coord_t [2:0] p2;
        coord_t [2:0] d2;
    } lines_t;

    typedef struct packed {
        logic signed [DOT_W-1:0] a;
        logic signed [DOT_W-1:0] b;
        logic signed [DOT_W-1:0] d;
        logic signed [DOT_W-1:0] c;
        logic signed [DOT_W-1:0] f;
        lines_t                  ln;
    } dots_t;

    // Partial products of a 50 x 50 signed multiply, split at bit 25.
    typedef struct packed {
        logic        [49:0] ll;
        logic signed [50:0] lh;
        logic signed [50:0] hl;
        logic signed [49:0] hh;
    } pp_t;

    typedef struct packed {
        logic             par;
        logic             ovf1;
        logic             ovf2;
        logic             neg1;
        logic             neg2;
        logic [DEN_W-1:0] dvs;
        logic [DEN_W-1:0] rem1;
        logic [DEN_W-1:0] rem2;
        logic [Q_W-1:0]   nl1;
        logic [Q_W-1:0]   nl2;
        logic [Q_W-1:0]   q1;
        logic [Q_W-1:0]   q2;
        lines_t           ln;
    } div_t;

    typedef struct packed {
        logic                  found;
        logic signed [T_W-1:0] t1;
        logic signed [T_W-1:0] t2;
        lines_t                ln;
    } param_t;

    typedef struct packed {
        logic                  found;
        logic signed [T_W-1:0] t1;
        logic signed [T_W-1:0] t2;
        coord_t [2:0]          q1;
        coord_t [2:0]          q2;
    } res_t;

    function automatic pp_t mul_part(input logic signed [DOT_W-1:0] x,
                                     input logic signed [DOT_W-1:0] y);
        pp_t r;
        r.ll = x[24:0] * y[24:0];
        r.lh = $signed({1'b0, x[24:0]}) * $signed(y[49:25]);
        r.hl = $signed(x[49:25]) * $signed({1'b0, y[24:0]});
        r.hh = $signed(x[49:25]) * $signed(y[49:25]);
        return r;
    endfunction

    function automatic logic signed [PROD_W-1:0] mul_join(input pp_t p);
        logic [PROD_W-1:0] hh_w;
        logic [PROD_W-1:0] lh_w;
        logic [PROD_W-1:0] hl_w;
        logic [PROD_W-1:0] ll_w;
        hh_w = {p.hh, 50'b0};
        lh_w = {{24{p.lh[50]}}, p.lh, 25'b0};
        hl_w = {{24{p.hl[50]}}, p.hl, 25'b0};
        ll_w = {50'b0, p.ll};
        return $signed(hh_w + lh_w + hl_w + ll_w);
    endfunction

endpackage

// File: hw/rtl/clp_dot.sv
module clp_dot
    import clp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  lines_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output dots_t  out_data
);

    localparam int N = 3;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_in;
    logic [N:0]   adv;

    always_comb
    begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign vld_in    = {vld_reg[N-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    lines_t              ln0_reg;
    logic signed [24:0]  dp0_reg [3];
    logic signed [24:0]  dp0_next [3];
    lines_t              ln1_reg;
    logic signed [47:0]  ad_reg [3];
    logic signed [47:0]  bb_reg [3];
    logic signed [47:0]  dd_reg [3];
    logic signed [48:0]  cc_reg [3];
    logic signed [48:0]  ff_reg [3];
    logic signed [47:0]  ad_next [3];
    logic signed [47:0]  bb_next [3];
    logic signed [47:0]  dd_next [3];
    logic signed [48:0]  cc_next [3];
    logic signed [48:0]  ff_next [3];
    dots_t               out_reg;
    dots_t               out_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dp0_next[i] = $signed(in_data.p1[i]) - $signed(in_data.p2[i]);
            ad_next[i]  = $signed(ln0_reg.d1[i]) * $signed(ln0_reg.d2[i]);
            bb_next[i]  = $signed(ln0_reg.d1[i]) * $signed(ln0_reg.d1[i]);
            dd_next[i]  = $signed(ln0_reg.d2[i]) * $signed(ln0_reg.d2[i]);
            cc_next[i]  = $signed(ln0_reg.d1[i]) * dp0_reg[i];
            ff_next[i]  = $signed(ln0_reg.d2[i]) * dp0_reg[i];
        end
        out_next.a  = 50'(ad_reg[0]) + 50'(ad_reg[1]) + 50'(ad_reg[2]);
        out_next.b  = 50'(bb_reg[0]) + 50'(bb_reg[1]) + 50'(bb_reg[2]);
        out_next.d  = 50'(dd_reg[0]) + 50'(dd_reg[1]) + 50'(dd_reg[2]);
        out_next.c  = 50'(cc_reg[0]) + 50'(cc_reg[1]) + 50'(cc_reg[2]);
        out_next.f  = 50'(ff_reg[0]) + 50'(ff_reg[1]) + 50'(ff_reg[2]);
        out_next.ln = ln1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ln0_reg <= in_data;
            dp0_reg <= dp0_next;
        end
        if (adv[1])
        begin
            ln1_reg <= ln0_reg;
            ad_reg  <= ad_next;
            bb_reg  <= bb_next;
            dd_reg  <= dd_next;
            cc_reg  <= cc_next;
            ff_reg  <= ff_next;
        end
        if (adv[2])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// File: hw/rtl/clp_solve.sv
module clp_solve
    import clp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LIM_W-1:0] limit,
    input  logic             in_valid,
    output logic             in_ready,
    input  dots_t            in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output div_t             out_data
);

    localparam int N = 5;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_in;
    logic [N:0]   adv;

    always_comb
    begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign vld_in    = {vld_reg[N-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    // Product order: a*a, b*d, c*d, a*f, c*a, b*f.
    pp_t                      pp_reg [6];
    pp_t                      pp_next [6];
    logic signed [PROD_W-1:0] prod_reg [6];
    logic signed [PROD_W-1:0] prod_next [6];
    logic signed [PROD_W-1:0] den_reg;
    logic signed [PROD_W-1:0] n1_reg;
    logic signed [PROD_W-1:0] n2_reg;
    logic [PROD_W-1:0]        dabs_next;
    logic [PROD_W-1:0]        n1abs_next;
    logic [PROD_W-1:0]        n2abs_next;
    logic [DEN_W-1:0]         dmag_reg;
    logic [NUM_W-1:0]         nmag1_reg;
    logic [NUM_W-1:0]         nmag2_reg;
    logic                     neg1_reg;
    logic                     neg2_reg;
    lines_t                   ln0_reg;
    lines_t                   ln1_reg;
    lines_t                   ln2_reg;
    lines_t                   ln3_reg;
    div_t                     out_reg;
    div_t                     out_next;

    always_comb
    begin
        pp_next[0] = mul_part(in_data.a, in_data.a);
        pp_next[1] = mul_part(in_data.b, in_data.d);
        pp_next[2] = mul_part(in_data.c, in_data.d);
        pp_next[3] = mul_part(in_data.a, in_data.f);
        pp_next[4] = mul_part(in_data.c, in_data.a);
        pp_next[5] = mul_part(in_data.b, in_data.f);
        for (int j = 0; j < 6; j++)
        begin
            prod_next[j] = mul_join(pp_reg[j]);
        end
        dabs_next  = den_reg[PROD_W-1] ? 100'(-den_reg) : den_reg;
        n1abs_next = n1_reg[PROD_W-1] ? 100'(-n1_reg) : n1_reg;
        n2abs_next = n2_reg[PROD_W-1] ? 100'(-n2_reg) : n2_reg;

        // The quotient fits in Q_W bits exactly when |n| < |den| * 2^25.
        out_next.par  = dmag_reg <= {49'b0, limit};
        out_next.ovf1 = {23'b0, nmag1_reg} >= {dmag_reg, 25'b0};
        out_next.ovf2 = {23'b0, nmag2_reg} >= {dmag_reg, 25'b0};
        out_next.neg1 = neg1_reg;
        out_next.neg2 = neg2_reg;
        out_next.dvs  = dmag_reg;
        out_next.rem1 = {23'b0, nmag1_reg[NUM_W-1:25]};
        out_next.rem2 = {23'b0, nmag2_reg[NUM_W-1:25]};
        out_next.nl1  = {nmag1_reg[24:0], 16'b0};
        out_next.nl2  = {nmag2_reg[24:0], 16'b0};
        out_next.q1   = '0;
        out_next.q2   = '0;
        out_next.ln   = ln3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pp_reg  <= pp_next;
            ln0_reg <= in_data.ln;
        end
        if (adv[1])
        begin
            prod_reg <= prod_next;
            ln1_reg  <= ln0_reg;
        end
        if (adv[2])
        begin
            den_reg <= prod_reg[0] - prod_reg[1];
            n1_reg  <= prod_reg[2] - prod_reg[3];
            n2_reg  <= prod_reg[4] - prod_reg[5];
            ln2_reg <= ln1_reg;
        end
        if (adv[3])
        begin
            dmag_reg  <= dabs_next[DEN_W-1:0];
            nmag1_reg <= n1abs_next[NUM_W-1:0];
            nmag2_reg <= n2abs_next[NUM_W-1:0];
            neg1_reg  <= n1_reg[PROD_W-1] ^ den_reg[PROD_W-1];
            neg2_reg  <= n2_reg[PROD_W-1] ^ den_reg[PROD_W-1];
            ln3_reg   <= ln2_reg;
        end
        if (adv[4])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// File: hw/rtl/clp_div.sv
module clp_div
    import clp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  div_t   in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output param_t out_data
);

    // One quotient bit per stage for both parameters, then a saturation stage.
    localparam int N = Q_W + 1;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_in;
    logic [N:0]   adv;

    always_comb
    begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign vld_in    = {vld_reg[N-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    function automatic div_t div_step(input div_t s);
        div_t         r;
        logic [DEN_W:0] t1;
        logic [DEN_W:0] t2;
        r  = s;
        t1 = {s.rem1, s.nl1[Q_W-1]};
        t2 = {s.rem2, s.nl2[Q_W-1]};
        if (t1 >= {1'b0, s.dvs})
        begin
            r.rem1 = DEN_W'(t1 - {1'b0, s.dvs});
            r.q1   = {s.q1[Q_W-2:0], 1'b1};
        end
        else
        begin
            r.rem1 = t1[DEN_W-1:0];
            r.q1   = {s.q1[Q_W-2:0], 1'b0};
        end
        if (t2 >= {1'b0, s.dvs})
        begin
            r.rem2 = DEN_W'(t2 - {1'b0, s.dvs});
            r.q2   = {s.q2[Q_W-2:0], 1'b1};
        end
        else
        begin
            r.rem2 = t2[DEN_W-1:0];
            r.q2   = {s.q2[Q_W-2:0], 1'b0};
        end
        r.nl1 = {s.nl1[Q_W-2:0], 1'b0};
        r.nl2 = {s.nl2[Q_W-2:0], 1'b0};
        return r;
    endfunction

    function automatic logic signed [T_W-1:0] sat_t(input logic [Q_W-1:0] q,
                                                    input logic neg,
                                                    input logic ovf);
        if (!neg)
        begin
            return (ovf || q > {1'b0, T_MAX}) ? T_MAX : T_W'(q);
        end
        return (ovf || q > {1'b0, T_MIN}) ? T_MIN : T_W'(-q);
    endfunction

    div_t st_reg [Q_W];
    div_t st_next [Q_W];

    genvar gk;
    generate
        for (gk = 0; gk < Q_W; gk++)
        begin : g_step
            if (gk == 0)
            begin : g_first
                assign st_next[gk] = div_step(in_data);
            end
            else
            begin : g_rest
                assign st_next[gk] = div_step(st_reg[gk-1]);
            end

            always_ff @(posedge clk)
            begin
                if (adv[gk])
                begin
                    st_reg[gk] <= st_next[gk];
                end
            end
        end
    endgenerate

    param_t out_reg;
    param_t out_next;
    div_t   last;

    always_comb
    begin
        last           = st_reg[Q_W-1];
        out_next.found = !last.par;
        out_next.t1    = last.par ? '0 : sat_t(last.q1, last.neg1, last.ovf1);
        out_next.t2    = last.par ? '0 : sat_t(last.q2, last.neg2, last.ovf2);
        out_next.ln    = last.ln;
    end

    always_ff @(posedge clk)
    begin
        if (adv[N-1])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// File: hw/rtl/clp_point.sv
module clp_point
    import clp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  param_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output res_t   out_data
);

    localparam int N = 3;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_in;
    logic [N:0]   adv;

    always_comb
    begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign vld_in    = {vld_reg[N-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    // Coordinates 0..2 belong to line one, 3..5 to line two.
    logic signed [T_W-1:0] tv [6];
    coord_t                dv [6];
    coord_t                pv [6];
    logic signed [44:0]    pl_reg [6];
    logic signed [43:0]    ph_reg [6];
    logic signed [44:0]    pl_next [6];
    logic signed [43:0]    ph_next [6];
    logic signed [47:0]    sh_reg [6];
    logic [63:0]           prod [6];
    logic signed [48:0]    sum [6];
    param_t                pr0_reg;
    param_t                pr1_reg;
    res_t                  out_reg;
    res_t                  out_next;
    coord_t                qv [6];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tv[i]   = in_data.t1;
            tv[i+3] = in_data.t2;
            dv[i]   = in_data.ln.d1[i];
            dv[i+3] = in_data.ln.d2[i];
            pv[i]   = pr1_reg.ln.p1[i];
            pv[i+3] = pr1_reg.ln.p2[i];
        end
        for (int j = 0; j < 6; j++)
        begin
            pl_next[j] = $signed({1'b0, tv[j][19:0]}) * $signed(dv[j]);
            ph_next[j] = $signed(tv[j][T_W-1:20]) * $signed(dv[j]);
            prod[j]    = {ph_reg[j], 20'b0} + {{19{pl_reg[j][44]}}, pl_reg[j]};
            sum[j]     = 49'($signed(pv[j])) + 49'(sh_reg[j]);
            if (!pr1_reg.found)
            begin
                qv[j] = '0;
            end
            else if (sum[j][48:23] == {26{sum[j][48]}})
            begin
                qv[j] = sum[j][23:0];
            end
            else
            begin
                qv[j] = sum[j][48] ? 24'sh800000 : 24'sh7FFFFF;
            end
        end
        out_next.found = pr1_reg.found;
        out_next.t1    = pr1_reg.t1;
        out_next.t2    = pr1_reg.t2;
        for (int i = 0; i < 3; i++)
        begin
            out_next.q1[i] = qv[i];
            out_next.q2[i] = qv[i+3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pl_reg  <= pl_next;
            ph_reg  <= ph_next;
            pr0_reg <= in_data;
        end
        if (adv[1])
        begin
            // Dropping the low 16 bits of the product rounds toward minus infinity.
            for (int j = 0; j < 6; j++)
            begin
                sh_reg[j] <= $signed(prod[j][63:16]);
            end
            pr1_reg <= pr0_reg;
        end
        if (adv[2])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// File: hw/rtl/closest_points_two_lines_top.sv
// Throughput: one request per cycle unless m_tready holds the output back; the divider's
// 41 quotient stages each retire one quotient bit for both line parameters, and all
// stages advance independently.
// Reset (rst_n low, asynchronous) empties every pipeline stage and sets the
// parallel limit to 281474977.
module closest_points_two_lines_top
    import clp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // p1_x, p1_y, p1_z, d1_x, d1_y, d1_z, p2_x, p2_y, p2_z, d2_x, d2_y, d2_z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // t_one, t_two, q1_x, q1_y, q1_z, q2_x, q2_y, q2_z
    output logic [223:0] m_tdata,
    // found
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [47:0]  cfg_data
);

    logic [LIM_W-1:0] limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    lines_t in_lines;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_lines.p1[i] = s_tdata[24*i +: 24];
            in_lines.d1[i] = s_tdata[72 + 24*i +: 24];
            in_lines.p2[i] = s_tdata[144 + 24*i +: 24];
            in_lines.d2[i] = s_tdata[216 + 24*i +: 24];
        end
    end

    logic   dot_valid;
    logic   dot_ready;
    dots_t  dot_data;
    logic   slv_valid;
    logic   slv_ready;
    div_t   slv_data;
    logic   div_valid;
    logic   div_ready;
    param_t div_data;
    res_t   res;

    clp_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_lines),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .out_data  (dot_data)
    );

    clp_solve u_solve (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .in_valid  (dot_valid),
        .in_ready  (dot_ready),
        .in_data   (dot_data),
        .out_valid (slv_valid),
        .out_ready (slv_ready),
        .out_data  (slv_data)
    );

    clp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (slv_valid),
        .in_ready  (slv_ready),
        .in_data   (slv_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    clp_point u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {res.q2[2], res.q2[1], res.q2[0],
                      res.q1[2], res.q1[1], res.q1[0],
                      res.t2, res.t1};
    assign m_tuser = res.found;

`ifndef SYNTH
    // A parallel result carries no parameters and no points.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("parallel result with nonzero payload");

    // An empty or draining output stage lets every stage advance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("pipeline stalled while output can move");

    // A parallel result reports both line parameters as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (res.t1 == '0 && res.t2 == '0))
        else $error("parallel result with nonzero parameter");
`endif

endmodule

// File: tb/tb_closest_points_two_lines_top.sv
module tb_closest_points_two_lines_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clp_pkg::*;

    localparam int LATENCY = 53;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic                  found;
        logic signed [39:0]    t1;
        logic signed [39:0]    t2;
        logic signed [23:0]    q1x;
        logic signed [23:0]    q1y;
        logic signed [23:0]    q1z;
        logic signed [23:0]    q2x;
        logic signed [23:0]    q2y;
        logic signed [23:0]    q2z;
    } closest_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Q24.16 quotient of num/den, truncated toward zero and saturated to 40 bits.
    function automatic logic signed [39:0] line_param(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
        logic [143:0] n;
        logic [143:0] dm;
        logic [143:0] q;
        logic         neg;
        neg = num[127] ^ den[127];
        n = num[127] ? 144'(-num) : 144'(num);
        dm = den[127] ? 144'(-den) : 144'(den);
        q = (n << 16) / dm;
        if (neg)
        begin
            if (q > 144'd549755813888)
                return T_MIN;
            return 40'(-$signed({1'b0, q[142:0]}));
        end
        if (q > 144'd549755813887)
            return T_MAX;
        return q[39:0];
    endfunction

    function automatic logic signed [23:0] along_line(input logic signed [23:0] p,
                                                      input logic signed [39:0] t,
                                                      input logic signed [23:0] dv);
        logic signed [63:0] prod;
        logic signed [63:0] s;
        prod = 64'(t) * 64'(dv);
        s = 64'(p) + (prod >>> 16);
        if (s > 64'sd8388607)
            return 24'sh7FFFFF;
        if (s < -64'sd8388608)
            return 24'sh800000;
        return s[23:0];
    endfunction

    function automatic closest_t solve_lines(input logic [287:0] raw,
                                             input logic [47:0] limit);
        logic signed [23:0]  v [12];
        logic signed [63:0]  w [12];
        logic signed [63:0]  dp [3];
        logic signed [63:0]  a, b, d, c, f;
        logic signed [127:0] den, n1, n2, mag;
        closest_t            r;
        for (int i = 0; i < 12; i++)
        begin
            v[i] = raw[24*i +: 24];
            w[i] = 64'(v[i]);
        end
        for (int i = 0; i < 3; i++)
            dp[i] = w[i] - w[6+i];
        a = w[3]*w[9] + w[4]*w[10] + w[5]*w[11];
        b = w[3]*w[3] + w[4]*w[4] + w[5]*w[5];
        d = w[9]*w[9] + w[10]*w[10] + w[11]*w[11];
        c = w[3]*dp[0] + w[4]*dp[1] + w[5]*dp[2];
        f = w[9]*dp[0] + w[10]*dp[1] + w[11]*dp[2];
        den = 128'(a)*128'(a) - 128'(b)*128'(d);
        mag = den < 0 ? -den : den;
        r = '0;
        if (mag <= 128'(limit))
            return r;
        n1 = 128'(c)*128'(d) - 128'(a)*128'(f);
        n2 = 128'(c)*128'(a) - 128'(b)*128'(f);
        r.found = 1'b1;
        r.t1 = line_param(n1, den);
        r.t2 = line_param(n2, den);
        r.q1x = along_line(v[0], r.t1, v[3]);
        r.q1y = along_line(v[1], r.t1, v[4]);
        r.q1z = along_line(v[2], r.t1, v[5]);
        r.q2x = along_line(v[6], r.t2, v[9]);
        r.q2y = along_line(v[7], r.t2, v[10]);
        r.q2z = along_line(v[8], r.t2, v[11]);
        return r;
    endfunction

    class closest_scoreboard;
        logic [47:0] limit = LIMIT_RESET;
        closest_t    pending[$];

        function void note_request(input logic [287:0] raw);
            pending.push_back(solve_lines(raw, limit));
        endfunction

        task check_result(input logic [223:0] data, input logic found);
            closest_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(data), 64'd0);
                return;
            end
            e = pending.pop_front();
            if (found !== e.found) report_mismatch("found", 64'(found), 64'(e.found));
            if (data[39:0] !== e.t1) report_mismatch("t_one", 64'(data[39:0]), 64'(e.t1));
            if (data[79:40] !== e.t2) report_mismatch("t_two", 64'(data[79:40]), 64'(e.t2));
            if (data[103:80] !== e.q1x) report_mismatch("q1_x", 64'(data[103:80]), 64'(e.q1x));
            if (data[127:104] !== e.q1y)
                report_mismatch("q1_y", 64'(data[127:104]), 64'(e.q1y));
            if (data[151:128] !== e.q1z)
                report_mismatch("q1_z", 64'(data[151:128]), 64'(e.q1z));
            if (data[175:152] !== e.q2x)
                report_mismatch("q2_x", 64'(data[175:152]), 64'(e.q2x));
            if (data[199:176] !== e.q2y)
                report_mismatch("q2_y", 64'(data[199:176]), 64'(e.q2y));
            if (data[223:200] !== e.q2z)
                report_mismatch("q2_z", 64'(data[223:200]), 64'(e.q2z));
        endtask
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [223:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [47:0]  cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    closest_scoreboard board = new();

    closest_points_two_lines_top dut (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser, .cfg_valid, .cfg_ready, .cfg_data
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser[0]);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_closest_points_two_lines_top: done, errors");
            $finish;
        end
    end

    task automatic send_lines(input logic [287:0] raw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= raw;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(raw);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.limit = value;
    endtask

    function automatic logic [23:0] rand_coord(input int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed(11'($urandom)));
            2: return 24'($signed(17'($urandom)));
            default: return 24'($urandom_range(2)) == 0 ? 24'h7FFFFF :
                            ($urandom_range(1) ? 24'h800000 : 24'($signed(6'($urandom))));
        endcase
    endfunction

    function automatic logic [287:0] rand_lines();
        logic [287:0] raw;
        int           mode;
        int           i;
        mode = $urandom_range(3);
        for (i = 0; i < 12; i++)
            raw[24*i +: 24] = rand_coord($urandom_range(4) == 0 ? $urandom_range(3) : mode);
        // Now and then make the lines parallel or nearly so, or zero the second direction.
        if ($urandom_range(9) == 0)
        begin
            for (i = 0; i < 3; i++)
                raw[24*(9+i) +: 24] = raw[24*(3+i) +: 24] + 24'($urandom_range(2)) - 24'd1;
        end
        else if ($urandom_range(19) == 0)
            raw[216 +: 72] = '0;
        return raw;
    endfunction

    function automatic logic [287:0] pack_lines(input int px, py, pz, ux, uy, uz,
                                                input int qx, qy, qz, vx, vy, vz);
        return {24'(vz), 24'(vy), 24'(vx), 24'(qz), 24'(qy), 24'(qx),
                24'(uz), 24'(uy), 24'(ux), 24'(pz), 24'(py), 24'(px)};
    endfunction

    initial
    begin
        logic [47:0] limits [4];
        limits = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'd281474977, 48'd1 << 40};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: axes, skew, parallel, degenerate and extreme values.
        send_lines(pack_lines(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 0, 0, 4096));
        send_lines(pack_lines(4096, 8192, -4096, 4096, 4096, 0, 0, 0, 4096, 0, 4096, 4096));
        send_lines(pack_lines(0, 0, 0, 4096, 0, 0, 0, 4096, 0, 8192, 0, 0));
        send_lines(pack_lines(0, 0, 0, 0, 0, 0, 100, 200, 300, 0, 4096, 0));
        send_lines('0);
        send_lines('1);
        send_lines({12{24'h7FFFFF}});
        send_lines({12{24'h800000}});
        send_lines({{3{24'h7FFFFF}}, {3{24'h800000}}, {3{24'h800000}}, {3{24'h7FFFFF}}});
        send_lines(pack_lines(8388607, -8388608, 8388607, 1, 0, 0, -8388608, 8388607, 0,
                              0, 1, 0));
        send_lines(pack_lines(8388607, 0, 0, 8388607, 1, 0, -8388608, 0, 0, 0, 8388607, 1));
        send_lines(pack_lines(0, 0, 0, 1, 0, 0, 8388607, 8388607, 8388607, 0, 1, 0));
        send_lines(pack_lines(0, 0, 0, 4096, 1, 0, 5000, -70, 3, 4096, 0, 1));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_limit(limits[phase]);
            send_idle_pct = phase == 0 ? 10 : (phase == 1 ? 88 : 0);
            recv_idle_pct = phase == 0 ? 88 : (phase == 1 ? 10 : 0);
            if (phase == 3)
            begin
                @(posedge clk);
                write_limit(48'($urandom) << $urandom_range(16));
            end
            for (int k = 0; k < 350; k++)
                send_lines(rand_lines());
            drain();
        end

        if (error_count == 0)
            $display("tb_closest_points_two_lines_top: done, clean");
        else
            $display("tb_closest_points_two_lines_top: done, errors");
        $finish;
    end
endmodule
